// ===== rtl/tma_pkg.sv =====
// Constants, types and microcode ROM for the thermistor moving-average block.
package tma_pkg;

  localparam int RING_DEPTH = 16;

  localparam int SAMPLE_W = 10;
  localparam int SLOT_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W    = $clog2(RING_DEPTH + 1);
  localparam int SUM_W    = SAMPLE_W + CNT_W;
  localparam int DIVD_W   = 2 * ((SUM_W + 8 + 1) / 2);
  localparam int DIV_STEPS = DIVD_W / 2;
  localparam int ITER_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int AVG_W  = 18;
  localparam int CFG_W  = 20;
  localparam int PROD_W = AVG_W + 1 + CFG_W;
  localparam int CRAW_W = 24;
  localparam int C_W    = 23;
  localparam int F_W    = 24;
  localparam int N_W    = 29;
  localparam int NU_W   = 28;
  localparam int FQ_W   = 25;
  localparam int FV_W   = 26;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;

  // floor((18c + 5) / 10) computed on a positive value: bias by 10 * 2^23
  localparam logic signed [N_W-1:0]  F_BIAS   = 29'sd83886085;
  localparam logic [NU_W-1:0]        F_MAGIC  = 28'd214748365;
  localparam int                     F_SHIFT  = 31;
  localparam logic signed [FV_W-1:0] F_DROP   = 26'sd8380416;

  localparam logic signed [C_W-1:0]  C_MAX     = 23'sd4194303;
  localparam logic signed [C_W-1:0]  C_MIN     = -23'sd4194304;
  localparam logic signed [C_W-1:0]  C_INVALID = -23'sd256000;
  localparam logic signed [F_W-1:0]  F_MAX     = 24'sd8388607;
  localparam logic signed [F_W-1:0]  F_MIN     = -24'sd8388608;
  localparam logic signed [F_W-1:0]  F_INVALID = -24'sd256000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_WALK,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_AVG,
    OP_MUL,
    OP_CSUM,
    OP_FMUL,
    OP_OUT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_WALK_MORE,
    COND_ITER_MORE,
    COND_OUT_BUSY
  } cond_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_WALK     = 4'd1;
  localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd3;
  localparam logic [PC_W-1:0] PC_AVG      = 4'd4;
  localparam logic [PC_W-1:0] PC_MUL      = 4'd5;
  localparam logic [PC_W-1:0] PC_CSUM     = 4'd6;
  localparam logic [PC_W-1:0] PC_FMUL     = 4'd7;
  localparam logic [PC_W-1:0] PC_OUT      = 4'd8;
  localparam logic [PC_W-1:0] PC_BACK     = 4'd9;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:     w = '{op: OP_IDLE,     cond: COND_NO_INPUT,  target: PC_IDLE};
      PC_WALK:     w = '{op: OP_WALK,     cond: COND_WALK_MORE, target: PC_WALK};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: PC_IDLE};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_ITER_MORE, target: PC_DIV_STEP};
      PC_AVG:      w = '{op: OP_AVG,      cond: COND_NEVER,     target: PC_IDLE};
      PC_MUL:      w = '{op: OP_MUL,      cond: COND_NEVER,     target: PC_IDLE};
      PC_CSUM:     w = '{op: OP_CSUM,     cond: COND_NEVER,     target: PC_IDLE};
      PC_FMUL:     w = '{op: OP_FMUL,     cond: COND_NEVER,     target: PC_IDLE};
      PC_OUT:      w = '{op: OP_OUT,      cond: COND_OUT_BUSY,  target: PC_OUT};
      PC_BACK:     w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: PC_IDLE};
      default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/thermistor_moving_average.sv =====
// Thermistor sample smoothing, min/max tracking and linear calibration.
// One transaction is processed at a time. After acceptance the sequencer walks the ring,
// reading W slots (W from 1 to 16) up to and including the first empty slot, runs the
// 12 steps of the 2-bit-per-cycle average divider, then the average, multiply, Celsius
// and Fahrenheit steps, and offers the result. After the result is loaded, the sequencer
// passes through the BACK step before it can accept the next transaction.
// A finished result is held in the output register while the next transaction is
// accepted; if that result is still waiting when the next one is done, the sequencer
// stalls. Control is a microcode ROM driving a single datapath; config writes must be
// made only while no transaction is in flight.
module thermistor_moving_average import tma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // sample[9:0], zero pad
  input  logic                 s_tuser,   // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // raw_value[9:0], average_q8[27:10], max_seen[37:28], min_seen[47:38],
  // temp_c_q8[70:48], temp_f_q8[94:71], zero pad
  output logic [95:0]          m_tdata,
  output logic                 m_tuser    // temp_valid
);

  logic                       invert_sample;
  logic signed [CFG_W-1:0]    slope_q16;
  logic signed [CFG_W-1:0]    intercept_q8;

  logic [PC_W-1:0]            pc;
  logic [PC_W-1:0]            pc_next;
  uword_t                     uw;
  logic                       cond_true;

  logic [SAMPLE_W-1:0]        ring [RING_DEPTH];
  logic [SLOT_W-1:0]          write_slot;
  logic [SLOT_W-1:0]          walk_idx;
  logic [SUM_W-1:0]           sum;
  logic [CNT_W-1:0]           count;
  logic                       cmd_q;
  logic [SAMPLE_W-1:0]        raw_q;
  logic [DIVD_W-1:0]          quo;
  logic [CNT_W-1:0]           rem;
  logic [ITER_W-1:0]          iter;
  logic [AVG_W-1:0]           avg;
  logic [SAMPLE_W-1:0]        running_max;
  logic [SAMPLE_W-1:0]        running_min;
  logic signed [PROD_W-1:0]   prod;
  logic signed [CRAW_W-1:0]   c_raw;
  logic [FQ_W-1:0]            f_quo;

  logic [SAMPLE_W-1:0]        entry;
  logic                       entry_nz;
  logic [SAMPLE_W-1:0]        s_in;
  logic                       accept;
  logic                       out_busy;
  logic                       out_load;

  logic [CNT_W:0]             r1, r2;
  logic                       ge1, ge2;
  logic [CNT_W-1:0]           rem1, rem2;

  logic [AVG_W-1:0]           avg_calc;
  logic [SAMPLE_W-1:0]        tracked;
  logic signed [PROD_W-1:0]   prod_calc;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [CRAW_W-1:0]   c_calc;
  logic signed [N_W-1:0]      n_s;
  logic [2*NU_W-1:0]          fprod;
  logic signed [FV_W-1:0]     f_val;
  logic signed [C_W-1:0]      c_out;
  logic signed [F_W-1:0]      f_out;
  logic                       t_valid;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_sample <= 1'b0;
      slope_q16     <= '0;
      intercept_q8  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_INVERT:    invert_sample <= cfg_wdata[0];
        CFG_SLOPE:     slope_q16     <= cfg_wdata;
        CFG_INTERCEPT: intercept_q8  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  assign uw = ucode(pc);
  assign entry    = ring[walk_idx];
  assign entry_nz = (entry != '0);
  assign out_busy = m_tvalid && !m_tready;

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:     cond_true = 1'b0;
      COND_ALWAYS:    cond_true = 1'b1;
      COND_NO_INPUT:  cond_true = !s_tvalid;
      COND_WALK_MORE: cond_true = entry_nz && (walk_idx != SLOT_W'(RING_DEPTH - 1));
      COND_ITER_MORE: cond_true = (iter != '0);
      COND_OUT_BUSY:  cond_true = out_busy;
      default:        cond_true = 1'b1;
    endcase
  end

  assign pc_next  = cond_true ? uw.target : pc + PC_W'(1);
  assign s_tready = (uw.op == OP_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_load = (uw.op == OP_OUT) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) pc <= PC_IDLE;
    else     pc <= pc_next;
  end

  // datapath
  assign s_in = invert_sample ? (SAMPLE_MAX - s_tdata[SAMPLE_W-1:0]) : s_tdata[SAMPLE_W-1:0];

  always_comb begin
    r1   = {rem, quo[DIVD_W-1]};
    ge1  = (r1 >= {1'b0, count});
    rem1 = ge1 ? CNT_W'(r1 - {1'b0, count}) : r1[CNT_W-1:0];
    r2   = {rem1, quo[DIVD_W-2]};
    ge2  = (r2 >= {1'b0, count});
    rem2 = ge2 ? CNT_W'(r2 - {1'b0, count}) : r2[CNT_W-1:0];
  end

  assign avg_calc  = (count == '0) ? '0 : quo[AVG_W-1:0];
  assign tracked   = cmd_q ? raw_q : avg_calc[AVG_W-1:8];
  assign prod_calc = $signed({1'b0, avg}) * slope_q16;
  assign prod_rnd  = prod + PROD_W'(32768);
  assign c_calc    = CRAW_W'(prod_rnd >>> 16) + CRAW_W'(intercept_q8);
  assign n_s       = (N_W'(c_raw) <<< 4) + (N_W'(c_raw) <<< 1) + F_BIAS;
  assign fprod     = (2*NU_W)'(n_s[NU_W-1:0]) * (2*NU_W)'(F_MAGIC);
  assign f_val     = $signed(FV_W'({1'b0, f_quo})) - F_DROP;
  assign t_valid   = (slope_q16 != '0);

  always_comb begin
    if (!t_valid)                       c_out = C_INVALID;
    else if (c_raw > CRAW_W'(C_MAX))    c_out = C_MAX;
    else if (c_raw < CRAW_W'(C_MIN))    c_out = C_MIN;
    else                                c_out = C_W'(c_raw);
    if (!t_valid)                       f_out = F_INVALID;
    else if (f_val > FV_W'(F_MAX))      f_out = F_MAX;
    else if (f_val < FV_W'(F_MIN))      f_out = F_MIN;
    else                                f_out = F_W'(f_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) ring[i] <= '0;
      write_slot  <= '0;
      running_max <= '0;
      running_min <= SAMPLE_MAX;
      count       <= '0;
    end else begin
      if (accept) begin
        ring[write_slot] <= s_in;
        write_slot <= (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : write_slot + SLOT_W'(1);
        count      <= '0;
      end
      if (uw.op == OP_WALK && entry_nz) count <= count + CNT_W'(1);
      if (uw.op == OP_AVG) begin
        if (tracked > running_max) running_max <= tracked;
        if (tracked < running_min) running_min <= tracked;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_q    <= s_in;
      cmd_q    <= s_tuser;
      walk_idx <= '0;
      sum      <= '0;
    end
    unique case (uw.op)
      OP_WALK: begin
        if (entry_nz) begin
          sum      <= sum + SUM_W'(entry);
          walk_idx <= walk_idx + SLOT_W'(1);
        end
      end
      OP_DIV_INIT: begin
        quo  <= DIVD_W'({sum, 8'd0});
        rem  <= '0;
        iter <= ITER_W'(DIV_STEPS - 1);
      end
      OP_DIV_STEP: begin
        quo  <= {quo[DIVD_W-3:0], ge1, ge2};
        rem  <= rem2;
        iter <= iter - ITER_W'(1);
      end
      OP_AVG:  avg   <= avg_calc;
      OP_MUL:  prod  <= prod_calc;
      OP_CSUM: c_raw <= c_calc;
      OP_FMUL: f_quo <= fprod[F_SHIFT +: FQ_W];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, f_out, c_out, running_min, running_max, avg, raw_q};
      m_tuser <= t_valid;
    end
  end

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> (pc == PC_WALK))
    else $error("accepted transaction did not start the ring walk");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RING_DEPTH))
    else $error("walk count beyond ring depth");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && pc == PC_BACK))
    else $error("result load did not raise m_tvalid");

  a_idle_only_accept: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (pc == PC_IDLE))
    else $error("ready outside idle step");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for thermistor_moving_average with a scoreboard class and driver tasks.
`timescale 1ns / 1ps

module tb_top;
  import tma_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 205;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct {
    logic [SAMPLE_W-1:0]      raw_value;
    logic [AVG_W-1:0]         average_q8;
    logic [SAMPLE_W-1:0]      max_seen;
    logic [SAMPLE_W-1:0]      min_seen;
    logic signed [C_W-1:0]    temp_c_q8;
    logic signed [F_W-1:0]    temp_f_q8;
    logic                     temp_valid;
  } temp_result_t;

  class avg_scoreboard;
    logic [SAMPLE_W-1:0]   ring [RING_DEPTH];
    int unsigned           wr_slot;
    logic [SAMPLE_W-1:0]   hi_seen;
    logic [SAMPLE_W-1:0]   lo_seen;
    bit                    invert;
    logic signed [CFG_W-1:0] slope;
    logic signed [CFG_W-1:0] icpt;
    temp_result_t          pending_q [$];
    int                    n_err;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_slot = 0;
      hi_seen = '0;
      lo_seen = SAMPLE_MAX;
      invert  = 0;
      slope   = '0;
      icpt    = '0;
      n_err   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_INVERT:    invert = val[0];
        CFG_SLOPE:     slope  = val;
        CFG_INTERCEPT: icpt   = val;
        default: ;
      endcase
    endfunction

    static function longint floor_div10(longint n);
      if (n >= 0) return n / 10;
      return -((-n + 9) / 10);
    endfunction

    function void note_sample(bit cmd, logic [SAMPLE_W-1:0] smp);
      logic [SAMPLE_W-1:0] s;
      int unsigned sum, cnt, avg, tracked;
      bit stop;
      longint c_raw, c_sat, f_sat;
      temp_result_t r;
      s = invert ? SAMPLE_MAX - smp : smp;
      ring[wr_slot] = s;
      wr_slot = (wr_slot + 1) % RING_DEPTH;
      sum = 0;
      cnt = 0;
      stop = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        if (ring[i] == 0) stop = 1;
        if (!stop) begin
          sum += 32'(ring[i]);
          cnt++;
        end
      end
      avg = (cnt != 0) ? (sum << 8) / cnt : 0;
      avg = avg & 32'h3FFFF;
      tracked = cmd ? 32'(s) : (avg >> 8);
      if (tracked > 32'(SAMPLE_MAX)) tracked = 32'(SAMPLE_MAX);
      if (tracked > 32'(hi_seen)) hi_seen = SAMPLE_W'(tracked);
      if (tracked < 32'(lo_seen)) lo_seen = SAMPLE_W'(tracked);
      if (slope != 0) begin
        c_raw = longint'(icpt) + ((longint'(avg) * longint'(slope) + 32768) >>> 16);
        c_sat = c_raw;
        if (c_sat < longint'(C_MIN)) c_sat = longint'(C_MIN);
        if (c_sat > longint'(C_MAX)) c_sat = longint'(C_MAX);
        f_sat = floor_div10(c_raw * 18 + 5) + 8192;
        if (f_sat < longint'(F_MIN)) f_sat = longint'(F_MIN);
        if (f_sat > longint'(F_MAX)) f_sat = longint'(F_MAX);
      end else begin
        c_sat = longint'(C_INVALID);
        f_sat = longint'(F_INVALID);
      end
      r.raw_value  = s;
      r.average_q8 = AVG_W'(avg);
      r.max_seen   = hi_seen;
      r.min_seen   = lo_seen;
      r.temp_c_q8  = C_W'(c_sat);
      r.temp_f_q8  = F_W'(f_sat);
      r.temp_valid = (slope != 0);
      pending_q.push_back(r);
    endfunction

    function void cmp_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        n_err++;
      end
    endfunction

    function void check_result(logic [95:0] data, logic valid_bit);
      temp_result_t e, a;
      if (pending_q.size() == 0) begin
        $error("result with no pending expectation: tdata %h", data);
        n_err++;
        return;
      end
      e = pending_q.pop_front();
      a.raw_value  = data[9:0];
      a.average_q8 = data[27:10];
      a.max_seen   = data[37:28];
      a.min_seen   = data[47:38];
      a.temp_c_q8  = data[70:48];
      a.temp_f_q8  = data[94:71];
      a.temp_valid = valid_bit;
      cmp_field("raw_value",  e.raw_value,  a.raw_value);
      cmp_field("average_q8", e.average_q8, a.average_q8);
      cmp_field("max_seen",   e.max_seen,   a.max_seen);
      cmp_field("min_seen",   e.min_seen,   a.min_seen);
      cmp_field("temp_c_q8",  e.temp_c_q8,  a.temp_c_q8);
      cmp_field("temp_f_q8",  e.temp_f_q8,  a.temp_f_q8);
      cmp_field("temp_valid", e.temp_valid, a.temp_valid);
      if (data[95] !== 1'b0) begin
        $error("m_tdata pad mismatch: expected 0, actual %b", data[95]);
        n_err++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid = 0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;   // sample[9:0], zero pad
  logic                 s_tuser = 0;    // cmd
  logic                 m_tvalid;
  logic                 m_tready = 0;
  // raw_value[9:0], average_q8[27:10], max_seen[37:28], min_seen[47:38],
  // temp_c_q8[70:48], temp_f_q8[94:71], zero pad
  logic [95:0]          m_tdata;
  logic                 m_tuser;        // temp_valid

  avg_scoreboard sb;
  bit src_idle_en = 0;
  bit snk_idle_en = 0;
  int n_results   = 0;

  thermistor_moving_average i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  task automatic send_sample(bit cmd, logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {6'b0, smp};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(cmd, smp);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(bit inv, logic [CFG_W-1:0] slope, logic [CFG_W-1:0] icpt);
    cfg_put(CFG_INVERT, {19'b0, inv});
    cfg_put(CFG_SLOPE, slope);
    cfg_put(CFG_INTERCEPT, icpt);
    cfg_put(CFG_SPARE, CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
    cfg_wr_en <= 0;
  endtask

  // wait until every transaction has come back, then let the block go idle
  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 0;
    while (sb.pending_q.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_q.size() > 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
      sb.n_err++;
      sb.pending_q.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 20'h7FFFF;
      2:       return 20'h80000;
      3:       return $urandom_range(0, 1) ? 20'h00001 : 20'hFFFFF;
      default: return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_stored();
    case ($urandom_range(0, 39))
      0:       return '0;
      1:       return SAMPLE_MAX;
      2:       return 10'd1;
      default: return SAMPLE_W'($urandom_range(1, 1023));
    endcase
  endfunction

  // result side
  initial begin
    int gap;
    wait (rst == 0);
    forever begin
      gap = snk_idle_en ? $urandom_range(0, 3) : 0;
      if (n_results == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
      n_results++;
    end
  end

  initial begin
    #(10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    bit                  inv;
    logic [SAMPLE_W-1:0] stored;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 0;
    repeat (4) @(posedge clk);

    // reset settings: empty average and zero slope
    send_sample(0, 10'd0);
    send_sample(1, SAMPLE_MAX);
    settle();

    // fill the whole ring with full scale, then cut the walk with a zero
    set_config(0, 20'h7FFFF, 20'h80000);
    for (int i = 0; i < 15; i++) send_sample(1'(i % 2), SAMPLE_MAX);
    send_sample(1, 10'd0);
    settle();

    set_config(1, 20'h80000, 20'h7FFFF);
    send_sample(0, SAMPLE_MAX);
    send_sample(1, 10'd0);
    send_sample(0, 10'd1);
    settle();

    set_config(0, 20'h00001, 20'h00000);
    send_sample(0, 10'd512);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      inv = 1'($urandom_range(0, 1));
      set_config(inv, pick_coef(), pick_coef());
      src_idle_en = (p % 3 != 0);
      snk_idle_en = (p % 4 != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        stored = pick_stored();
        send_sample(1'($urandom_range(0, 1)), inv ? SAMPLE_MAX - stored : stored);
      end
      settle();
    end

    repeat (40) @(posedge clk);
    if (sb.n_err == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
